/* hdl/pattern_tile_store_decoder_unit_defines.svh */
// Assertion macros shared by the checker of the pattern tile store decoder.
// No dependencies; included by the files that assert.
`ifndef PATTERN_TILE_STORE_DECODER_UNIT_DEFINES_SVH
`define PATTERN_TILE_STORE_DECODER_UNIT_DEFINES_SVH

// checked only while out of reset
`define PTSD_ASSERT_RST(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// checked at every edge, reset included
`define PTSD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

/* hdl/ptsd_pkg.sv */
// Shared types, constants and helper functions of the pattern tile store decoder.
// No dependencies; used by the RTL modules other than ptsd_ram by scoped names.
package ptsd_pkg;

  localparam int STORE_BYTES = 8192;
  localparam int TILE_BYTES  = 16;
  localparam int TILE_COUNT  = STORE_BYTES / TILE_BYTES;
  localparam int ADDR_W      = 13;
  localparam int TILE_W      = 9;
  localparam int BYTE_W      = 8;
  localparam int PLANE_W     = 64;
  localparam int STRIPE_W    = 16;
  localparam int BIT_AW      = $clog2(TILE_BYTES);
  localparam int ROW_TILES   = 16;
  localparam int DIRTY_ROWS  = TILE_COUNT / ROW_TILES;
  localparam int ROW_AW      = $clog2(DIRTY_ROWS);
  localparam int TBIT_AW     = $clog2(ROW_TILES);
  localparam int CNT_W       = $clog2(TILE_BYTES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ACT_LOAD       = 2'd0;
  localparam logic [1:0] ACT_WRITE      = 2'd1;
  localparam logic [1:0] ACT_DECODE     = 2'd2;
  localparam logic [1:0] ACT_NEXT_DIRTY = 2'd3;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_WRITE,
    OP_DROP,
    OP_DECODE,
    OP_SCAN
  } op_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] value;
    logic [TILE_W-1:0] tile_index;
  } in_item_t;

  typedef struct packed {
    logic               tile_valid;
    logic [TILE_W-1:0]  tile_number;
    logic [PLANE_W-1:0] plane_low_rows;
    logic [PLANE_W-1:0] plane_high_rows;
    logic [PLANE_W-1:0] pixel_rows_first_half;
    logic [PLANE_W-1:0] pixel_rows_second_half;
    logic [BYTE_W-1:0]  tile_hash;
    logic               write_taken;
  } out_result_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] value;
    logic [TILE_W-1:0] tile;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  localparam out_result_t RESULT_NONE = '0;

  function automatic logic [STRIPE_W-1:0] interleave_row(input logic [BYTE_W-1:0] lo,
                                                         input logic [BYTE_W-1:0] hi);
    logic [STRIPE_W-1:0] s;
    s = '0;
    for (int j = 0; j < BYTE_W; j++) begin
      s[2*j]   = lo[j];
      s[2*j+1] = hi[j];
    end
    return s;
  endfunction

  function automatic logic [ROW_AW-1:0] lowest_row(input logic [DIRTY_ROWS-1:0] v);
    logic [ROW_AW-1:0] idx;
    idx = '0;
    for (int i = DIRTY_ROWS - 1; i >= 0; i--) begin
      if (v[i]) idx = ROW_AW'(i);
    end
    return idx;
  endfunction

  function automatic logic [TBIT_AW-1:0] lowest_tile(input logic [ROW_TILES-1:0] v);
    logic [TBIT_AW-1:0] idx;
    idx = '0;
    for (int i = ROW_TILES - 1; i >= 0; i--) begin
      if (v[i]) idx = TBIT_AW'(i);
    end
    return idx;
  endfunction

  function automatic out_result_t make_tile_result(input logic [TILE_W-1:0]  tile,
                                                   input logic [PLANE_W-1:0] p0,
                                                   input logic [PLANE_W-1:0] p1,
                                                   input logic [BYTE_W-1:0]  hash);
    out_result_t r;
    r = RESULT_NONE;
    r.tile_valid      = 1'b1;
    r.tile_number     = tile;
    r.plane_low_rows  = p0;
    r.plane_high_rows = p1;
    r.tile_hash       = hash;
    for (int i = 0; i < 4; i++) begin
      r.pixel_rows_first_half[STRIPE_W*i +: STRIPE_W] =
        interleave_row(p0[PLANE_W-1-BYTE_W*i -: BYTE_W], p1[PLANE_W-1-BYTE_W*i -: BYTE_W]);
      r.pixel_rows_second_half[STRIPE_W*i +: STRIPE_W] =
        interleave_row(p0[PLANE_W/2-1-BYTE_W*i -: BYTE_W],
                       p1[PLANE_W/2-1-BYTE_W*i -: BYTE_W]);
    end
    return r;
  endfunction

endpackage

/* hdl/ptsd_ram.sv */
// Generic single-port RAM with registered read data (read-first).
// No dependencies.
module ptsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ptsd_front.sv */
// Front end: accepts commands, classifies them against the ROM flag, queues them.
// Depends on ptsd_pkg.
module ptsd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  ptsd_pkg::in_item_t    in_item,
  output logic                  busy,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  output ptsd_pkg::queue_head_t head,
  input  logic                  pop
);

  logic                            rom_r;
  ptsd_pkg::cmd_t                  slots_r [ptsd_pkg::QUEUE_DEPTH];
  logic [ptsd_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [ptsd_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [ptsd_pkg::QCNT_W-1:0]     count_r;
  logic                            full;
  logic                            push;
  logic                            do_pop;
  ptsd_pkg::cmd_t                  cmd;

  assign full   = count_r == ptsd_pkg::QCNT_W'(ptsd_pkg::QUEUE_DEPTH);
  assign busy   = !rst_n || full;
  assign push   = start && !busy;
  assign do_pop = pop && (count_r != '0);

  always_comb begin
    cmd.address = in_item.address;
    cmd.value   = in_item.value;
    cmd.tile    = (in_item.action == ptsd_pkg::ACT_DECODE) ? in_item.tile_index :
                  in_item.address[ptsd_pkg::ADDR_W-1 -: ptsd_pkg::TILE_W];
    case (in_item.action)
      ptsd_pkg::ACT_LOAD:   cmd.op = ptsd_pkg::OP_LOAD;
      ptsd_pkg::ACT_WRITE:  cmd.op = rom_r ? ptsd_pkg::OP_DROP : ptsd_pkg::OP_WRITE;
      ptsd_pkg::ACT_DECODE: cmd.op = ptsd_pkg::OP_DECODE;
      default:              cmd.op = rom_r ? ptsd_pkg::OP_DROP : ptsd_pkg::OP_SCAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r    <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_we) begin
        rom_r <= cfg_wdata;
      end
      if (push) begin
        slots_r[wr_ptr_r] <= cmd;
        wr_ptr_r <= (wr_ptr_r == ptsd_pkg::QPTR_W'(ptsd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                    wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == ptsd_pkg::QPTR_W'(ptsd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                    rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head.valid = count_r != '0;
  assign head.cmd   = slots_r[rd_ptr_r];

endmodule

/* hdl/ptsd_back.sv */
// Back end: runs queued commands on the pattern store and dirty-mark store.
// Depends on ptsd_pkg and ptsd_ram.
module ptsd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptsd_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  output ptsd_pkg::out_result_t out_result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WCMP,
    S_SCAN,
    S_READ
  } state_t;

  state_t                              state_r;
  ptsd_pkg::cmd_t                      cmd_r;
  logic [ptsd_pkg::TILE_W-1:0]         tile_r;
  logic [ptsd_pkg::CNT_W-1:0]          cnt_r;
  logic [ptsd_pkg::PLANE_W-1:0]        p0_r;
  logic [ptsd_pkg::PLANE_W-1:0]        p1_r;
  logic [ptsd_pkg::BYTE_W-1:0]         hash_r;
  logic [ptsd_pkg::ROW_TILES-1:0]      drow_r;
  logic [ptsd_pkg::DIRTY_ROWS-1:0]     row_any_r;
  logic                                out_valid_r;
  ptsd_pkg::out_result_t               out_result_r;

  logic                                pat_we;
  logic [ptsd_pkg::ADDR_W-1:0]         pat_addr;
  logic [ptsd_pkg::BYTE_W-1:0]         pat_wdata;
  logic [ptsd_pkg::BYTE_W-1:0]         pat_rdata;
  logic                                dty_we;
  logic [ptsd_pkg::ROW_AW-1:0]         dty_addr;
  logic [ptsd_pkg::ROW_TILES-1:0]      dty_wdata;
  logic [ptsd_pkg::ROW_TILES-1:0]      dty_rdata;

  logic [ptsd_pkg::ROW_AW-1:0]         cur_row;
  logic [ptsd_pkg::TBIT_AW-1:0]        cur_bit;
  logic [ptsd_pkg::ROW_AW-1:0]         scan_row;
  logic [ptsd_pkg::ROW_TILES-1:0]      drow_m;
  logic [ptsd_pkg::ROW_TILES-1:0]      set_row;
  logic [ptsd_pkg::ROW_TILES-1:0]      clr_row;
  logic                                last;
  logic                                changed;
  logic [ptsd_pkg::PLANE_W-1:0]        fin_p1;
  logic [ptsd_pkg::BYTE_W-1:0]         fin_hash;

  ptsd_ram #(
    .WIDTH(ptsd_pkg::BYTE_W),
    .DEPTH(ptsd_pkg::STORE_BYTES)
  ) u_pattern_ram (
    .clk  (clk),
    .we   (pat_we),
    .addr (pat_addr),
    .wdata(pat_wdata),
    .rdata(pat_rdata)
  );

  ptsd_ram #(
    .WIDTH(ptsd_pkg::ROW_TILES),
    .DEPTH(ptsd_pkg::DIRTY_ROWS)
  ) u_dirty_ram (
    .clk  (clk),
    .we   (dty_we),
    .addr (dty_addr),
    .wdata(dty_wdata),
    .rdata(dty_rdata)
  );

  assign pop      = (state_r == S_IDLE) && head.valid;
  assign cur_row  = tile_r[ptsd_pkg::TILE_W-1 -: ptsd_pkg::ROW_AW];
  assign cur_bit  = tile_r[ptsd_pkg::TBIT_AW-1:0];
  assign scan_row = ptsd_pkg::lowest_row(row_any_r);
  // rows never marked are not trusted in the RAM
  assign drow_m   = row_any_r[cur_row] ? dty_rdata : '0;
  assign set_row  = drow_m | (ptsd_pkg::ROW_TILES'(1) << cur_bit);
  assign clr_row  = drow_r & ~(ptsd_pkg::ROW_TILES'(1) << cur_bit);
  assign last     = cnt_r == ptsd_pkg::CNT_W'(ptsd_pkg::TILE_BYTES);
  assign changed  = pat_rdata != cmd_r.value;
  assign fin_p1   = {p1_r[ptsd_pkg::PLANE_W-ptsd_pkg::BYTE_W-1:0], pat_rdata};
  assign fin_hash = hash_r ^ pat_rdata;

  always_comb begin
    pat_we    = 1'b0;
    pat_addr  = {tile_r, cnt_r[ptsd_pkg::BIT_AW-1:0]};
    pat_wdata = cmd_r.value;
    dty_we    = 1'b0;
    dty_addr  = cur_row;
    dty_wdata = set_row;
    case (state_r)
      S_IDLE: begin
        pat_addr  = head.cmd.address;
        pat_wdata = head.cmd.value;
        if (head.valid) begin
          case (head.cmd.op)
            ptsd_pkg::OP_LOAD:  pat_we = 1'b1;
            ptsd_pkg::OP_WRITE:
              dty_addr = head.cmd.tile[ptsd_pkg::TILE_W-1 -: ptsd_pkg::ROW_AW];
            ptsd_pkg::OP_SCAN:  dty_addr = scan_row;
            default: ;
          endcase
        end
      end
      S_WCMP: begin
        pat_addr = cmd_r.address;
        if (changed) begin
          pat_we = 1'b1;
          dty_we = 1'b1;
        end
      end
      S_READ: begin
        if (last) begin
          dty_we    = 1'b1;
          dty_wdata = clr_row;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_any_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            cmd_r  <= head.cmd;
            tile_r <= head.cmd.tile;
            cnt_r  <= '0;
            hash_r <= '0;
            case (head.cmd.op)
              ptsd_pkg::OP_LOAD: begin
                out_valid_r              <= 1'b1;
                out_result_r             <= ptsd_pkg::RESULT_NONE;
                out_result_r.write_taken <= 1'b1;
              end
              ptsd_pkg::OP_WRITE:  state_r <= S_WCMP;
              ptsd_pkg::OP_DECODE: state_r <= S_READ;
              ptsd_pkg::OP_SCAN: begin
                if (row_any_r != '0) begin
                  tile_r  <= {scan_row, {ptsd_pkg::TBIT_AW{1'b0}}};
                  state_r <= S_SCAN;
                end else begin
                  out_valid_r  <= 1'b1;
                  out_result_r <= ptsd_pkg::RESULT_NONE;
                end
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_result_r <= ptsd_pkg::RESULT_NONE;
              end
            endcase
          end
        end
        S_WCMP: begin
          out_valid_r              <= 1'b1;
          out_result_r             <= ptsd_pkg::RESULT_NONE;
          out_result_r.write_taken <= changed;
          if (changed) begin
            row_any_r[cur_row] <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          tile_r  <= {cur_row, ptsd_pkg::lowest_tile(drow_m)};
          cnt_r   <= '0;
          state_r <= S_READ;
        end
        S_READ: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == ptsd_pkg::CNT_W'(1)) begin
            drow_r <= drow_m;
          end
          if (cnt_r != '0) begin
            hash_r <= fin_hash;
            if (cnt_r <= ptsd_pkg::CNT_W'(ptsd_pkg::TILE_BYTES / 2)) begin
              p0_r <= {p0_r[ptsd_pkg::PLANE_W-ptsd_pkg::BYTE_W-1:0], pat_rdata};
            end else begin
              p1_r <= fin_p1;
            end
          end
          if (last) begin
            out_valid_r        <= 1'b1;
            out_result_r       <= ptsd_pkg::make_tile_result(tile_r, p0_r, fin_p1, fin_hash);
            row_any_r[cur_row] <= |clr_row;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

/* hdl/pattern_tile_store_decoder_unit.sv */
// Top level of the pattern tile store decoder: front end queue plus back end.
// Depends on ptsd_pkg, ptsd_front and ptsd_back.
//
// A command is taken while busy is low; busy stays high during reset and while
// the two-entry command queue is full. Every command yields exactly one result,
// shown for one cycle with out_valid; the receiver cannot hold it off. Load,
// ROM-ignored commands and empty take-next-dirty end in the idle state; a write
// reads the old byte, then compares and stores; a decode reads the sixteen
// bytes from the single-port pattern store and writes the dirty row back; a
// take-next-dirty first picks a tile from a dirty row. Results are registered,
// shown in the cycle after the back end ends. Dirty marks are held 16 per RAM
// row with a per-row summary register cleared at reset; no clearing pass needed.
module pattern_tile_store_decoder_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ptsd_pkg::in_item_t    in_item,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  output logic                  out_valid,
  output ptsd_pkg::out_result_t out_result
);

  ptsd_pkg::queue_head_t head;
  logic                  pop;

  ptsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .head     (head),
    .pop      (pop)
  );

  ptsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_result(out_result)
  );

endmodule

/* hdl/ptsd_checker.sv */
// Port-level checker for the pattern tile store decoder, bound to the top level.
// Depends on ptsd_pkg and pattern_tile_store_decoder_unit_defines.svh.
`include "pattern_tile_store_decoder_unit_defines.svh"

module ptsd_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input ptsd_pkg::out_result_t out_result
);

  logic [2:0] pend_r;
  logic       empty_result;
  logic       tile_clear;
  logic       both_kinds;
  logic       pend_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {2'b0, start && !busy} - {2'b0, out_valid};
    end
  end

  assign empty_result = out_valid && !out_result.tile_valid;
  assign tile_clear   = out_result.tile_hash == '0 && out_result.tile_number == '0 &&
                        out_result.plane_low_rows == '0;
  assign both_kinds   = out_result.tile_valid && out_result.write_taken;
  assign pend_ok      = pend_r != 3'd0 && pend_r <= 3'd4;

  `PTSD_ASSERT_RST(a_empty, clk, rst_n, empty_result |-> tile_clear, "tile data in empty result")
  `PTSD_ASSERT_RST(a_one_kind, clk, rst_n, out_valid |-> !both_kinds, "two result kinds at once")
  `PTSD_ASSERT_RST(a_no_orphan, clk, rst_n, out_valid |-> pend_ok, "result with nothing pending")
  `PTSD_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result strobe right after reset")
  `PTSD_ASSERT_ALWAYS(a_reset_busy, clk, !rst_n |-> busy, "commands taken during reset")

endmodule

bind pattern_tile_store_decoder_unit ptsd_checker u_ptsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_result(out_result)
);
